// File: rtl/core/smd_pkg.sv
package smd_pkg;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hFA;
   localparam logic [7:0] BUS_ID_BYTE   = 8'hFF;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_BID  = 3'd1;
   localparam logic [2:0] PH_MID  = 3'd2;
   localparam logic [2:0] PH_LEN  = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CS   = 3'd5;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_PAYLOAD = 2'd1;
   localparam logic [1:0] EV_GOOD    = 2'd2;
   localparam logic [1:0] EV_BADSUM  = 2'd3;

   typedef struct packed {
      logic [7:0] payload_index;
      logic [7:0] payload_byte;
      logic [7:0] message_id;
      logic [1:0] event_kind;
   } smd_result_type;

endpackage

// File: rtl/core/sensor_message_deframer.sv
// A result is registered in the output buffer, or in its skid stage while the output is stalled.
// Throughput: one byte per cycle while req_tready is high; the parser state updates on each accepted byte.
// A two-entry output buffer keeps req_tready high while one result waits.
// Reset is synchronous and active high: the parser returns to waiting for the
// preamble with sum, id, length and position cleared, and both buffers empty.
module sensor_message_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] message_id, [15:8] payload_byte, [23:16] payload_index
   output logic [1:0]  rsp_tuser    // [1:0] event_kind
);

   logic                    byte_fire;
   smd_pkg::smd_result_type parse_result;
   smd_pkg::smd_result_type out_result;

   assign byte_fire = req_tvalid && req_tready;

   smd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .rx_byte   (req_tdata),
      .result    (parse_result)
   );

   smd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (parse_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {out_result.payload_index, out_result.payload_byte,
                       out_result.message_id};
   assign rsp_tuser = out_result.event_kind;

endmodule

// File: rtl/core/smd_parser.sv
module smd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_fire,
   input  logic [7:0]             rx_byte,
   output smd_pkg::smd_result_type result
);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] sum_add;

   assign sum_add = sum_ff + rx_byte;

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      result.event_kind    = smd_pkg::EV_NONE;
      result.message_id    = 8'd0;
      result.payload_byte  = 8'd0;
      result.payload_index = 8'd0;
      case (phase_ff)
         smd_pkg::PH_IDLE: begin
            if (rx_byte == smd_pkg::PREAMBLE_BYTE) begin
               phase_in = smd_pkg::PH_BID;
               sum_in   = 8'd0;
               len_in   = 8'd0;
               pos_in   = 8'd0;
            end
         end
         smd_pkg::PH_BID: begin
            // Anything but the bus id byte is dropped without touching the sum.
            if (rx_byte == smd_pkg::BUS_ID_BYTE) begin
               sum_in   = sum_add;
               phase_in = smd_pkg::PH_MID;
            end
         end
         smd_pkg::PH_MID: begin
            sum_in   = sum_add;
            id_in    = rx_byte;
            phase_in = smd_pkg::PH_LEN;
         end
         smd_pkg::PH_LEN: begin
            sum_in   = sum_add;
            len_in   = rx_byte;
            phase_in = (rx_byte != 8'd0) ? smd_pkg::PH_DATA : smd_pkg::PH_CS;
         end
         smd_pkg::PH_DATA: begin
            sum_in = sum_add;
            pos_in = pos_ff + 8'd1;
            result.event_kind    = smd_pkg::EV_PAYLOAD;
            result.message_id    = id_ff;
            result.payload_byte  = rx_byte;
            result.payload_index = pos_ff;
            if (pos_in == len_ff) begin
               phase_in = smd_pkg::PH_CS;
            end
         end
         smd_pkg::PH_CS: begin
            sum_in   = sum_add;
            phase_in = smd_pkg::PH_IDLE;
            result.event_kind = (sum_add == 8'd0) ? smd_pkg::EV_GOOD : smd_pkg::EV_BADSUM;
            result.message_id = id_ff;
         end
         default: begin
            phase_in = smd_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= smd_pkg::PH_IDLE;
         sum_ff   <= 8'd0;
         id_ff    <= 8'd0;
         len_ff   <= 8'd0;
         pos_ff   <= 8'd0;
      end else if (byte_fire) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: rtl/core/smd_out_buf.sv
module smd_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  smd_pkg::smd_result_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output smd_pkg::smd_result_type out_data
);

   logic                    out_valid_ff;
   logic                    skid_valid_ff;
   smd_pkg::smd_result_type out_data_ff;
   smd_pkg::smd_result_type skid_data_ff;
   logic                    in_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // A transaction that arrives while the output is stalled parks in the skid stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_fire) begin
         if (!out_valid_ff || out_ready) begin
            out_data_ff  <= in_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

// File: rtl/core/smd_checker.sv
module smd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Only payload transactions carry a byte and an index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != smd_pkg::EV_PAYLOAD) |-> rsp_tdata[23:8] == 16'd0)
      else $error("payload fields set on a non-payload result");

   // An empty result carries no message id.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == smd_pkg::EV_NONE) |-> rsp_tdata[7:0] == 8'd0)
      else $error("message id set on an empty result");

   // After each accepted byte, rsp_tvalid is high in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted byte produced no result");

   assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("output not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind sensor_message_deframer smd_checker u_smd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
